>>> sv/scss_pkg.sv
// Shared types, constants and helper functions of the sound channel setup sequencer.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package scss_pkg;

	// Field widths
	localparam int OP_W    = 1;
	localparam int CH_W    = 6;
	localparam int SADDR_W = 23;
	localparam int FMT_W   = 2;
	localparam int SCNT_W  = 16;
	localparam int FREQ_W  = 21;
	localparam int BYTE_W  = 8;
	localparam int OFS_W   = 7;
	localparam int BADDR_W = CH_W + OFS_W;
	localparam int DATA_W  = 16;

	// Channel count; per-channel storage depth follows from it
	localparam int CHANNELS = 64;
	localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Operation codes
	localparam logic OP_PLAY = 1'b0;
	localparam logic OP_STOP = 1'b1;

	// Pitch conversion
	localparam logic [22:0] PITCH_BASE = 23'd5644800;
	localparam int          MAX_SHIFT  = 15;
	localparam int          SHIFT_W    = 4;
	localparam int          EXPO_W     = 5;
	localparam int          EXPO_TOP   = 7;
	localparam int          MANT_W     = 10;
	localparam int          DIV_STEPS  = 12;
	localparam int          DCNT_W     = $clog2(DIV_STEPS);

	// Control word bits
	localparam logic [DATA_W-1:0] CTRL_PLAY   = 16'h4200;
	localparam logic [DATA_W-1:0] CTRL_ENABLE = 16'hC000;
	localparam logic [DATA_W-1:0] CTRL_KEY    = 16'h4000;
	localparam logic [DATA_W-1:0] CTRL_OFF    = 16'h8000;
	localparam logic [DATA_W-1:0] CTRL_RESET  = 16'h8000;

	// Register offsets inside a channel slot
	localparam logic [OFS_W-1:0] OFS_CTRL    = 7'h00;
	localparam logic [OFS_W-1:0] OFS_ADDR_LO = 7'h04;
	localparam logic [OFS_W-1:0] OFS_COUNT   = 7'h0C;
	localparam logic [OFS_W-1:0] OFS_LOOP    = 7'h10;
	localparam logic [OFS_W-1:0] OFS_PITCH   = 7'h18;
	localparam logic [OFS_W-1:0] OFS_PAN     = 7'h24;
	localparam logic [OFS_W-1:0] OFS_ENV     = 7'h25;
	localparam logic [OFS_W-1:0] OFS_LFO     = 7'h28;
	localparam logic [OFS_W-1:0] OFS_VOLUME  = 7'h29;

	// Fixed register values
	localparam logic [BYTE_W-1:0] LFO_VALUE  = 8'h24;
	localparam logic [BYTE_W-1:0] ENV_VALUE  = 8'h0F;
	localparam logic [DATA_W-1:0] LOOP_VALUE = 16'h001F;

	// Steps of a play sequence
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_CTRL    = 4'd0;
	localparam logic [STEP_W-1:0] STEP_ADDR_LO = 4'd1;
	localparam logic [STEP_W-1:0] STEP_COUNT   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_PITCH   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_LFO     = 4'd4;
	localparam logic [STEP_W-1:0] STEP_ENV     = 4'd5;
	localparam logic [STEP_W-1:0] STEP_VOLUME  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_PAN     = 4'd7;
	localparam logic [STEP_W-1:0] STEP_LOOP    = 4'd8;
	localparam logic [STEP_W-1:0] STEP_ENABLE  = 4'd9;

	typedef struct packed {
		logic                op;
		logic [CH_W-1:0]     channel;
		logic [SADDR_W-1:0]  sample_address;
		logic [FMT_W-1:0]    sample_format;
		logic [SCNT_W-1:0]   sample_count;
		logic [DATA_W-1:0]   pitch;
		logic [BYTE_W-1:0]   volume;
		logic [BYTE_W-1:0]   pan;
	} cmd_t;

	typedef struct packed {
		logic [OFS_W-1:0]  ofs;
		logic [DATA_W-1:0] data;
		logic              byte_wr;
		logic              last;
	} wr_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_EMIT
	} back_state_t;

	function automatic logic [22:0] pitch_base(input logic [SHIFT_W-1:0] k);
		return PITCH_BASE >> k;
	endfunction

	// Number of halvings of the base: the bases fall monotonically, so the
	// last one still above the frequency sets the count.
	function automatic logic [SHIFT_W-1:0] norm_shift(input logic [FREQ_W-1:0] f);
		logic [SHIFT_W-1:0] k;
		k = '0;
		for (int j = 0; j < MAX_SHIFT; j++) begin
			if ({2'b00, f} < pitch_base(SHIFT_W'(j)))
				k = SHIFT_W'(j + 1);
		end
		return k;
	endfunction

	function automatic logic [DATA_W-1:0] play_ctrl(input cmd_t c);
		return CTRL_PLAY | {7'd0, c.sample_format, c.sample_address[22:16]};
	endfunction

	function automatic wr_t play_write(input logic [STEP_W-1:0] step, input cmd_t c);
		wr_t w;
		w = '{ofs: OFS_CTRL, data: play_ctrl(c), byte_wr: 1'b0, last: 1'b0};
		case (step)
			STEP_CTRL: begin
				w.ofs  = OFS_CTRL;
				w.data = play_ctrl(c);
			end
			STEP_ADDR_LO: begin
				w.ofs  = OFS_ADDR_LO;
				w.data = c.sample_address[15:0];
			end
			STEP_COUNT: begin
				w.ofs  = OFS_COUNT;
				w.data = c.sample_count;
			end
			STEP_PITCH: begin
				w.ofs  = OFS_PITCH;
				w.data = c.pitch;
			end
			STEP_LFO: begin
				w.ofs     = OFS_LFO;
				w.data    = {8'h00, LFO_VALUE};
				w.byte_wr = 1'b1;
			end
			STEP_ENV: begin
				w.ofs     = OFS_ENV;
				w.data    = {8'h00, ENV_VALUE};
				w.byte_wr = 1'b1;
			end
			STEP_VOLUME: begin
				w.ofs     = OFS_VOLUME;
				w.data    = {8'h00, c.volume};
				w.byte_wr = 1'b1;
			end
			STEP_PAN: begin
				w.ofs     = OFS_PAN;
				w.data    = {8'h00, c.pan};
				w.byte_wr = 1'b1;
			end
			STEP_LOOP: begin
				w.ofs  = OFS_LOOP;
				w.data = LOOP_VALUE;
			end
			STEP_ENABLE: begin
				w.ofs  = OFS_CTRL;
				w.data = play_ctrl(c) | CTRL_ENABLE;
				w.last = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> sv/scss_cmd_if.sv
// Command channel: valid/ready handshake with the play/stop command payload.
// Depends on scss_pkg for field widths.
`default_nettype none

interface scss_cmd_if;
	logic                            valid;
	logic                            ready;
	logic                            operation;
	logic [scss_pkg::CH_W-1:0]       channel;
	logic [scss_pkg::SADDR_W-1:0]    sample_address;
	logic [scss_pkg::FMT_W-1:0]      sample_format;
	logic [scss_pkg::SCNT_W-1:0]     sample_count;
	logic [scss_pkg::FREQ_W-1:0]     frequency;
	logic [scss_pkg::BYTE_W-1:0]     volume;
	logic [scss_pkg::BYTE_W-1:0]     pan;

	modport source (
		output valid, operation, channel, sample_address, sample_format,
			sample_count, frequency, volume, pan,
		input  ready
	);
	modport sink (
		input  valid, operation, channel, sample_address, sample_format,
			sample_count, frequency, volume, pan,
		output ready
	);
endinterface

`default_nettype wire

>>> sv/scss_wr_if.sv
// Register write channel: valid/ready handshake with one register write.
// Depends on scss_pkg for field widths.
`default_nettype none

interface scss_wr_if;
	logic                          valid;
	logic                          ready;
	logic [scss_pkg::BADDR_W-1:0]  byte_address;
	logic [scss_pkg::DATA_W-1:0]   write_data;
	logic                          byte_write;
	logic                          last_write;

	modport source (
		output valid, byte_address, write_data, byte_write, last_write,
		input  ready
	);
	modport sink (
		input  valid, byte_address, write_data, byte_write, last_write,
		output ready
	);
endinterface

`default_nettype wire

>>> sv/scss_front.sv
// Front end: accepts commands, drops bad channels, works out a play's pitch word
// with a bit-per-cycle divider and hands the finished command to the queue.
// Depends on scss_pkg and scss_cmd_if.
`default_nettype none

module scss_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	scss_cmd_if.sink            cmd,
	output logic                push,
	output scss_pkg::cmd_t      push_data,
	input  wire logic           full
);
	import scss_pkg::*;

	front_state_t state_q, state_d;

	cmd_t               stg_q;
	logic [22:0]        base_q;
	logic [22:0]        rem_q;
	logic [DIV_STEPS-1:0] sh_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic [EXPO_W-1:0]  expo_q;

	logic               in_range;
	logic [SHIFT_W-1:0] shift;
	logic [23:0]        trial;
	logic               ge;
	logic [23:0]        diff;
	logic               load;
	logic               step;

	assign in_range = {1'b0, cmd.channel} < (CH_W + 1)'(CHANNELS);
	assign shift    = norm_shift(cmd.frequency);

	// One restoring-division step: bring down the next dividend bit
	assign trial = {rem_q, sh_q[DIV_STEPS-1]};
	assign ge    = trial >= {1'b0, base_q};
	assign diff  = trial - {1'b0, base_q};

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		push      = 1'b0;
		load      = 1'b0;
		step      = 1'b0;
		push_data = stg_q;
		push_data.pitch = {expo_q, 1'b0, quo_q[MANT_W-1:0]};
		case (state_q)
			F_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid && in_range) begin
					load    = 1'b1;
					state_d = (cmd.operation == OP_STOP) ? F_PUSH : F_DIV;
				end
			end
			F_DIV: begin
				step = 1'b1;
				if (cnt_q == '0)
					state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			stg_q.op             <= cmd.operation;
			stg_q.channel        <= cmd.channel;
			stg_q.sample_address <= cmd.sample_address;
			stg_q.sample_format  <= cmd.sample_format;
			stg_q.sample_count   <= cmd.sample_count;
			stg_q.pitch          <= '0;
			stg_q.volume         <= cmd.volume;
			stg_q.pan            <= cmd.pan;
			base_q  <= pitch_base(shift);
			expo_q  <= EXPO_W'(EXPO_TOP) - {1'b0, shift};
			// dividend is frequency<<10; its top part stays below the base
			rem_q   <= {4'd0, cmd.frequency[FREQ_W-1:2]};
			sh_q    <= {cmd.frequency[1:0], {(DIV_STEPS - 2){1'b0}}};
			quo_q   <= '0;
			cnt_q   <= DCNT_W'(DIV_STEPS - 1);
		end else if (step) begin
			rem_q <= ge ? diff[22:0] : trial[22:0];
			sh_q  <= {sh_q[DIV_STEPS-2:0], 1'b0};
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> sv/scss_queue.sv
// Short command queue between the front end and the write sequencer.
// Depends on scss_pkg.
`default_nettype none

module scss_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire scss_pkg::cmd_t push_data,
	output logic                full,
	input  wire logic           pop,
	output scss_pkg::cmd_t      head,
	output logic                empty
);
	import scss_pkg::*;

	localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t            slot_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wptr_q, rptr_q;
	logic [QC_W-1:0] count_q;

	assign full  = count_q == QC_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rptr_q];

	function automatic logic [QA_W-1:0] wrap_inc(input logic [QA_W-1:0] p);
		return (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wrap_inc(wptr_q);
			if (pop)
				rptr_q <= wrap_inc(rptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_data;
	end

endmodule

`default_nettype wire

>>> sv/scss_back.sv
// Write sequencer: takes commands from the queue, emits the register writes in
// order through an output register and keeps the per-channel control word copy.
// Depends on scss_pkg and scss_wr_if.
`default_nettype none

module scss_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire scss_pkg::cmd_t head,
	input  wire logic           empty,
	output logic                pop,
	scss_wr_if.source           wr
);
	import scss_pkg::*;

	back_state_t state_q, state_d;

	cmd_t               cmd_q;
	logic [STEP_W-1:0]  step_q;
	logic [DATA_W-1:0]  copy_rd_q;
	logic               copy_vld_rd_q;
	logic [DATA_W-1:0]  copy_mem [CHANNELS];
	logic [CHANNELS-1:0] copy_vld_q;

	logic               wr_vld_q;
	logic [BADDR_W-1:0] wr_addr_q;
	logic [DATA_W-1:0]  wr_data_q;
	logic               wr_byte_q;
	logic               wr_last_q;

	logic [DATA_W-1:0]  copy;
	wr_t                cur;
	logic               load;
	logic               mem_we;

	assign copy = copy_vld_rd_q ? copy_rd_q : CTRL_RESET;

	always_comb begin
		if (cmd_q.op == OP_STOP)
			cur = '{ofs: OFS_CTRL, data: (copy & ~CTRL_KEY) | CTRL_OFF,
				byte_wr: 1'b0, last: 1'b1};
		else
			cur = play_write(step_q, cmd_q);
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (!wr_vld_q || wr.ready) begin
					load = 1'b1;
					if (cur.last)
						state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// The last write of every command is the control word; record it
	assign mem_we = load && cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			wr_vld_q   <= 1'b0;
			copy_vld_q <= '0;
		end else begin
			state_q <= state_d;
			if (load)
				wr_vld_q <= 1'b1;
			else if (wr.ready)
				wr_vld_q <= 1'b0;
			if (mem_we)
				copy_vld_q[cmd_q.channel[CH_AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			copy_mem[cmd_q.channel[CH_AW-1:0]] <= cur.data;
		if (pop) begin
			copy_rd_q     <= copy_mem[head.channel[CH_AW-1:0]];
			copy_vld_rd_q <= copy_vld_q[head.channel[CH_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= head;
			step_q <= STEP_CTRL;
		end else if (load) begin
			step_q <= step_q + 1'b1;
		end
		if (load) begin
			wr_addr_q <= {cmd_q.channel, cur.ofs};
			wr_data_q <= cur.data;
			wr_byte_q <= cur.byte_wr;
			wr_last_q <= cur.last;
		end
	end

	assign wr.valid        = wr_vld_q;
	assign wr.byte_address = wr_addr_q;
	assign wr.write_data   = wr_data_q;
	assign wr.byte_write   = wr_byte_q;
	assign wr.last_write   = wr_last_q;

endmodule

`default_nettype wire

>>> sv/sound_channel_setup_sequencer_top.sv
// Channel   Dir   Payload
// cmd       in    operation, channel, sample_address, sample_format,
//                 sample_count, frequency, volume, pan
// wr        out   byte_address, write_data, byte_write, last_write
//
// A play command passes the front end in order (accept, 12 divider steps for
// the pitch mantissa, queue handoff) and no new command is accepted until it
// is handed off; the sequencer then emits ten writes. A stop skips the divider
// and makes one write. Reset returns every control copy to 0x8000
// at once through per-channel valid bits. A stall on wr holds the output
// register; the two-entry queue then fills and cmd.ready drops.
// Depends on scss_pkg, scss_cmd_if, scss_wr_if, scss_front, scss_queue, scss_back.
`default_nettype none

module sound_channel_setup_sequencer_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	scss_cmd_if.sink   cmd,
	scss_wr_if.source  wr
);
	import scss_pkg::*;

	logic push, full, pop, empty;
	cmd_t push_data, head;

	scss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	scss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	scss_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.wr     (wr)
	);

endmodule

`default_nettype wire

>>> test/sound_channel_setup_sequencer_top_tb.sv
// Testbench for sound_channel_setup_sequencer_top: plays and stops with a local
// prediction of every register write, checked in order under four idling phases.
// Depends on scss_pkg, scss_cmd_if, scss_wr_if and the sequencer RTL.

module sound_channel_setup_sequencer_top_tb;
	import scss_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_PRINTS   = 40;
	localparam logic [31:0] BASE_RATE = 32'd5644800;

	typedef struct {
		logic               op;
		logic [CH_W-1:0]    channel;
		logic [SADDR_W-1:0] address;
		logic [FMT_W-1:0]   format;
		logic [SCNT_W-1:0]  count;
		logic [FREQ_W-1:0]  frequency;
		logic [BYTE_W-1:0]  volume;
		logic [BYTE_W-1:0]  pan;
	} sound_cmd_t;

	typedef struct {
		logic [BADDR_W-1:0] address;
		logic [DATA_W-1:0]  data;
		logic               byte_wr;
		logic               last;
	} reg_write_t;

	logic clk;
	logic arst_n;

	scss_cmd_if cmd_ch ();
	scss_wr_if  wr_ch ();

	sound_channel_setup_sequencer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.wr     (wr_ch)
	);

	reg_write_t        pending_writes[$];
	logic [DATA_W-1:0] control_shadow[CHANNELS];
	int idle_pct;
	int stall_pct;
	int error_count;
	int cycle_count;
	int writes_checked;
	int play_count;
	int stop_count;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = OP_PLAY;
		cmd_ch.channel = '0;
		cmd_ch.sample_address = '0;
		cmd_ch.sample_format = '0;
		cmd_ch.sample_count = '0;
		cmd_ch.frequency = '0;
		cmd_ch.volume = '0;
		cmd_ch.pan = '0;
		wr_ch.ready = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d writes outstanding", cycle_count,
				pending_writes.size());
			$display("sound_channel_setup_sequencer_top_tb: FAIL");
			$finish;
		end
	end

	// Receiver stall: redraw ready every cycle.
	always @(negedge clk)
		wr_ch.ready = ($urandom_range(0, 99) >= stall_pct);

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Exponent starts at 7 and drops with each halving of the base, floor -8.
	function automatic logic [DATA_W-1:0] rate_to_pitch(input logic [FREQ_W-1:0] f);
		logic [31:0] base;
		logic [31:0] mant;
		int          expo;
		base = BASE_RATE;
		expo = 7;
		while ({11'd0, f} < base && expo > -8) begin
			base = base >> 1;
			expo--;
		end
		mant = ({11'd0, f} << 10) / base;
		return {expo[4:0], 1'b0, mant[9:0]};
	endfunction

	task automatic add_write(input logic [CH_W-1:0] ch, input logic [OFS_W-1:0] ofs,
			input logic [DATA_W-1:0] data, input logic bw, input logic last);
		reg_write_t w;
		w.address = {ch, ofs};
		w.data    = data;
		w.byte_wr = bw;
		w.last    = last;
		pending_writes.push_back(w);
	endtask

	task automatic expand_command(input sound_cmd_t c);
		logic [DATA_W-1:0] w0;
		if (c.channel < CHANNELS) begin
			if (c.op == OP_STOP) begin
				w0 = (control_shadow[c.channel] & ~CTRL_KEY) | CTRL_OFF;
				control_shadow[c.channel] = w0;
				add_write(c.channel, OFS_CTRL, w0, 1'b0, 1'b1);
				stop_count++;
			end else begin
				w0 = CTRL_PLAY | {7'd0, c.format, c.address[22:16]};
				add_write(c.channel, OFS_CTRL, w0, 1'b0, 1'b0);
				add_write(c.channel, OFS_ADDR_LO, c.address[15:0], 1'b0, 1'b0);
				add_write(c.channel, OFS_COUNT, c.count, 1'b0, 1'b0);
				add_write(c.channel, OFS_PITCH, rate_to_pitch(c.frequency), 1'b0, 1'b0);
				add_write(c.channel, OFS_LFO, {8'h00, LFO_VALUE}, 1'b1, 1'b0);
				add_write(c.channel, OFS_ENV, {8'h00, ENV_VALUE}, 1'b1, 1'b0);
				add_write(c.channel, OFS_VOLUME, {8'h00, c.volume}, 1'b1, 1'b0);
				add_write(c.channel, OFS_PAN, {8'h00, c.pan}, 1'b1, 1'b0);
				add_write(c.channel, OFS_LOOP, LOOP_VALUE, 1'b0, 1'b0);
				control_shadow[c.channel] = w0 | CTRL_ENABLE;
				add_write(c.channel, OFS_CTRL, w0 | CTRL_ENABLE, 1'b0, 1'b1);
				play_count++;
			end
		end
	endtask

	always @(posedge clk) begin : check_writes
		reg_write_t exp_wr;
		if (arst_n && wr_ch.valid && wr_ch.ready) begin
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected write addr=%h data=%h byte=%b last=%b",
					wr_ch.byte_address, wr_ch.write_data, wr_ch.byte_write,
					wr_ch.last_write));
			end else begin
				exp_wr = pending_writes.pop_front();
				writes_checked++;
				if (wr_ch.byte_address !== exp_wr.address || wr_ch.write_data !== exp_wr.data ||
						wr_ch.byte_write !== exp_wr.byte_wr ||
						wr_ch.last_write !== exp_wr.last)
					report_mismatch($sformatf(
						"write got addr=%h data=%h byte=%b last=%b, want %h %h %b %b",
						wr_ch.byte_address, wr_ch.write_data, wr_ch.byte_write,
						wr_ch.last_write, exp_wr.address, exp_wr.data, exp_wr.byte_wr,
						exp_wr.last));
			end
		end
	end

	task automatic send_command(input sound_cmd_t c);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.operation      = c.op;
		cmd_ch.channel        = c.channel;
		cmd_ch.sample_address = c.address;
		cmd_ch.sample_format  = c.format;
		cmd_ch.sample_count   = c.count;
		cmd_ch.frequency      = c.frequency;
		cmd_ch.volume         = c.volume;
		cmd_ch.pan            = c.pan;
		cmd_ch.valid          = 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		expand_command(c);
	endtask

	// Drop valid once a test has sent its last transfer.
	task automatic release_cmd();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
	endtask

	function automatic sound_cmd_t make_cmd(input logic op, input int ch, input int addr,
			input int fmt, input int cnt, input int freq, input int vol, input int pan);
		sound_cmd_t c;
		c.op        = op;
		c.channel   = CH_W'(ch);
		c.address   = SADDR_W'(addr);
		c.format    = FMT_W'(fmt);
		c.count     = SCNT_W'(cnt);
		c.frequency = FREQ_W'(freq);
		c.volume    = BYTE_W'(vol);
		c.pan       = BYTE_W'(pan);
		return c;
	endfunction

	task automatic test_extremes();
		send_command(make_cmd(OP_PLAY, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_PLAY, 63, 23'h7FFFFF, 3, 16'hFFFF, 21'h1FFFFF, 255, 255));
		send_command(make_cmd(OP_PLAY, 1, 23'h2AAAAA, 1, 16'h5555, 44100, 8'hA5, 8'h5A));
		send_command(make_cmd(OP_PLAY, 2, 23'h555555, 2, 16'hAAAA, 22050, 8'h5A, 8'hA5));
		release_cmd();
	endtask

	task automatic test_stop();
		// Untouched channel keeps its reset copy; a replayed channel rekeys first.
		send_command(make_cmd(OP_STOP, 5, 23'h7FFFFF, 3, 16'hFFFF, 21'h1FFFFF, 255, 255));
		send_command(make_cmd(OP_STOP, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_STOP, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(OP_PLAY, 0, 23'h7F0000, 3, 100, 8000, 1, 2));
		send_command(make_cmd(OP_STOP, 0, 0, 0, 0, 0, 0, 0));
		release_cmd();
	endtask

	task automatic test_pitch_edges();
		int shifts[3] = '{2, 8, 15};
		foreach (shifts[i]) begin
			send_command(make_cmd(OP_PLAY, 10 + i, 0, 0, 0, int'(BASE_RATE >> shifts[i]),
				0, 0));
			send_command(make_cmd(OP_PLAY, 20 + i, 0, 0, 0,
				int'(BASE_RATE >> shifts[i]) - 1, 0, 0));
		end
		// Below the smallest base: exponent clamps at its floor.
		send_command(make_cmd(OP_PLAY, 30, 0, 0, 0, 171, 0, 0));
		send_command(make_cmd(OP_PLAY, 31, 0, 0, 0, 1, 0, 0));
		release_cmd();
	endtask

	function automatic sound_cmd_t random_cmd();
		sound_cmd_t c;
		int k;
		c.op = ($urandom_range(0, 99) < 55) ? OP_PLAY : OP_STOP;
		// Favor a few channels so stops land on played channels.
		c.channel = $urandom_range(0, 1) ? CH_W'($urandom_range(0, 7))
			: CH_W'($urandom_range(0, 63));
		c.address = SADDR_W'($urandom);
		c.format  = FMT_W'($urandom_range(0, 3));
		c.count   = SCNT_W'($urandom);
		c.volume  = BYTE_W'($urandom);
		c.pan     = BYTE_W'($urandom);
		case ($urandom_range(0, 3))
			0: c.frequency = FREQ_W'($urandom);
			1: c.frequency = FREQ_W'($urandom_range(0, 400));
			2: begin
				k = $urandom_range(2, 15);
				c.frequency = FREQ_W'(int'(BASE_RATE >> k) + $urandom_range(0, 2) - 1);
			end
			default: c.frequency = FREQ_W'($urandom_range(0, 65535));
		endcase
		return c;
	endfunction

	task automatic test_random(input int idle, input int stall, input int count);
		idle_pct  = idle;
		stall_pct = stall;
		repeat (count)
			send_command(random_cmd());
		release_cmd();
	endtask

	initial begin
		idle_pct = 0;
		stall_pct = 0;
		error_count = 0;
		cycle_count = 0;
		writes_checked = 0;
		play_count = 0;
		stop_count = 0;
		foreach (control_shadow[i])
			control_shadow[i] = CTRL_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_stop();
		test_pitch_edges();
		test_random(0, 0, 90);
		test_random(77, 0, 90);
		test_random(0, 77, 90);
		test_random(6, 6, 95);

		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d plays and %0d stops, %0d register writes checked",
			play_count, stop_count, writes_checked);
		$display("idling phases: none, sender gaps, receiver stalls, light on both sides");
		if (error_count == 0 && pending_writes.size() == 0)
			$display("sound_channel_setup_sequencer_top_tb: PASS");
		else
			$display("sound_channel_setup_sequencer_top_tb: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
sv/scss_pkg.sv
sv/scss_cmd_if.sv
sv/scss_wr_if.sv
sv/scss_front.sv
sv/scss_queue.sv
sv/scss_back.sv
sv/sound_channel_setup_sequencer_top.sv
test/sound_channel_setup_sequencer_top_tb.sv
